FILE: src/co2_sensor_frame_checker_macros.svh
// Assertion macros used by the checking file co2fc_checker.sv.
`ifndef CO2_SENSOR_FRAME_CHECKER_MACROS_SVH
`define CO2_SENSOR_FRAME_CHECKER_MACROS_SVH

// Checked on every edge outside reset.
`define CO2FC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define CO2FC_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/co2fc_pkg.sv
package co2fc_pkg;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } byte_item_t;

  typedef struct packed {
    logic [31:0] co2_value;
    logic [15:0] temperature_raw;
    logic        status;
  } result_item_t;

  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  // Byte positions inside the nine-byte frame.
  localparam logic [3:0] POS_FIRST = 4'd0;
  localparam logic [3:0] POS_CRC0  = 4'd2;
  localparam logic [3:0] POS_CRC1  = 4'd5;
  localparam logic [3:0] POS_LAST  = 4'd8;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_CRC_ERR = 1'b1;

endpackage

FILE: src/co2_sensor_frame_checker.sv
// Channel  | Handshake                  | Payload
// byte     | byte_valid / byte_ready    | byte_item   (rx_byte, frame_start)
// result   | result_valid / result_ready| result_item (co2_value, temperature_raw, status)
//
// One byte per cycle is sustained unless a stalled result holds back the input; the
// CRC byte update is a shallow XOR network. An accepted byte waits in the input
// register for the frame logic; the result register loads when the ninth byte is processed.
// Reset is synchronous and clears the frame position, the CRC, the error flag and
// both valid flags. A stalled result holds back the byte that would produce the
// next result, and with it every byte behind it.
module co2_sensor_frame_checker (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    byte_valid,
  output logic                    byte_ready,
  input  co2fc_pkg::byte_item_t   byte_item,
  output logic                    result_valid,
  input  logic                    result_ready,
  output co2fc_pkg::result_item_t result_item
);

  // The input register holds one accepted item for the frame logic.
  logic                    hold_valid;
  co2fc_pkg::byte_item_t   hold_item;

  logic                    emit;
  logic                    step;
  co2fc_pkg::result_item_t frame_result;

  co2fc_frame_track u_frame (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (hold_item),
    .emit   (emit),
    .result (frame_result)
  );

  // The held item moves on unless it would produce a result while the result
  // register is still full and not being taken.
  assign step       = hold_valid && (!emit || !result_valid || result_ready);
  assign byte_ready = !hold_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (byte_ready) begin
      hold_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_ready && byte_valid) begin
      hold_item <= byte_item;
    end
  end

  // Result register: loaded when the last byte of a frame is processed.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (step && emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      result_item <= frame_result;
    end
  end

endmodule

FILE: src/co2fc_crc8.sv
// One byte of CRC-8, MSB first, unrolled into XOR logic.
module co2fc_crc8 (
  input  logic [7:0] crc_in,
  input  logic [7:0] data_in,
  output logic [7:0] crc_out
);

  always_comb begin
    logic [7:0] c;
    c = crc_in ^ data_in;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ co2fc_pkg::CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule

FILE: src/co2fc_frame_track.sv
// Frame position, per-group CRC and data byte collection.
module co2fc_frame_track (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     step,
  input  co2fc_pkg::byte_item_t    item,
  output logic                     emit,
  output co2fc_pkg::result_item_t  result
);

  logic [3:0]  byte_position;
  logic [7:0]  running_crc;
  logic [47:0] data_bytes;
  logic        crc_failed;

  logic        restart;
  logic [3:0]  pos_eff;
  logic [7:0]  crc_eff;
  logic        failed_eff;
  logic        is_check;
  logic        bad;
  logic [7:0]  crc_updated;

  // Out-of-range positions are treated like a restart.
  assign restart    = item.frame_start || (byte_position > co2fc_pkg::POS_LAST);
  assign pos_eff    = restart ? co2fc_pkg::POS_FIRST : byte_position;
  assign crc_eff    = restart ? co2fc_pkg::CRC_INIT : running_crc;
  assign failed_eff = restart ? 1'b0 : crc_failed;

  assign is_check = pos_eff inside {co2fc_pkg::POS_CRC0, co2fc_pkg::POS_CRC1,
                                    co2fc_pkg::POS_LAST};
  assign emit     = (pos_eff == co2fc_pkg::POS_LAST);
  assign bad      = (item.rx_byte != crc_eff);

  co2fc_crc8 u_crc (
    .crc_in  (crc_eff),
    .data_in (item.rx_byte),
    .crc_out (crc_updated)
  );

  always_comb begin
    result.co2_value       = data_bytes[47:16];
    result.temperature_raw = data_bytes[15:0];
    result.status          = (failed_eff || bad) ? co2fc_pkg::STATUS_CRC_ERR
                                                 : co2fc_pkg::STATUS_OK;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= co2fc_pkg::POS_FIRST;
      running_crc   <= co2fc_pkg::CRC_INIT;
      crc_failed    <= 1'b0;
    end else if (step) begin
      if (is_check) begin
        running_crc <= co2fc_pkg::CRC_INIT;
        if (emit) begin
          crc_failed    <= 1'b0;
          byte_position <= co2fc_pkg::POS_FIRST;
        end else begin
          crc_failed    <= failed_eff || bad;
          byte_position <= pos_eff + 4'd1;
        end
      end else begin
        running_crc   <= crc_updated;
        crc_failed    <= failed_eff;
        byte_position <= pos_eff + 4'd1;
      end
    end
  end

  // Every complete frame shifts in all six data bytes before its last byte.
  always_ff @(posedge clk) begin
    if (step && !is_check) begin
      data_bytes <= {data_bytes[39:0], item.rx_byte};
    end
  end

endmodule

FILE: src/co2fc_checker.sv
`include "co2_sensor_frame_checker_macros.svh"

// Port-level checks on the frame checker.
module co2fc_checker (
  input logic                    clk,
  input logic                    rst,
  input logic                    byte_valid,
  input logic                    byte_ready,
  input co2fc_pkg::byte_item_t   byte_item,
  input logic                    result_valid,
  input logic                    result_ready,
  input co2fc_pkg::result_item_t result_item
);

  `CO2FC_ASSERT(a_result_holds, result_valid && !result_ready |=> result_valid && $stable(result_item), "result changed while stalled")
  `CO2FC_ASSERT_ALWAYS(a_reset_clears_result, rst |=> !result_valid, "result valid after reset")
  `CO2FC_ASSERT_ALWAYS(a_reset_opens_input, rst |=> byte_ready, "input not ready after reset")
  `CO2FC_ASSERT(a_result_has_source, $rose(result_valid) |-> $past(byte_valid && byte_ready, 2) || $past(!byte_ready, 2), "result without a byte in flight")

endmodule

bind co2_sensor_frame_checker co2fc_checker u_co2fc_checker (.*);
